### rtl/bresenham_line_rasterizer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the line rasterizer
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_RASTERIZER_ASSERT_SVH
`define BRESENHAM_LINE_RASTERIZER_ASSERT_SVH

`ifndef SYNTHESIS

// check a property on every clock edge outside reset
`define BLR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("blr assertion failed");

// check a property on every clock edge, reset included
`define BLR_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("blr assertion failed");

`else

`define BLR_ASSERT(label, clk, rst_n, prop)
`define BLR_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

### rtl/blr_pkg.sv
// ----------------------------------------------------------------------------
// Line rasterizer package
// Widths and beat types shared by the rasterizer modules and interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package blr_pkg;

    localparam int COORD_BITS = 10;
    localparam int COLOR_BITS = 32;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [COLOR_BITS-1:0] t_color;
    // error term carries one extra bit for the sign
    typedef logic signed [COORD_BITS:0] t_err;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_STEP = 1'b1
    } t_action;

    typedef struct packed {
        t_action action;
        t_coord  x_start;
        t_coord  y_start;
        t_coord  x_end;
        t_coord  y_end;
        t_color  color;
    } t_item;

    typedef struct packed {
        t_coord pixel_x;
        t_coord pixel_y;
        t_color pixel_color;
        logic   last_pixel;
    } t_pixel;

endpackage

`default_nettype wire

### rtl/blr_line_if.sv
// ----------------------------------------------------------------------------
// Line command channel
// Valid/ready channel carrying load and step beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface blr_line_if;
    import blr_pkg::*;

    logic    valid;
    logic    ready;
    t_action action;
    t_coord  x_start;
    t_coord  y_start;
    t_coord  x_end;
    t_coord  y_end;
    t_color  color;

    modport source (
        output valid, action, x_start, y_start, x_end, y_end, color,
        input  ready
    );

    modport sink (
        input  valid, action, x_start, y_start, x_end, y_end, color,
        output ready
    );
endinterface

`default_nettype wire

### rtl/blr_pixel_if.sv
// ----------------------------------------------------------------------------
// Pixel channel
// Valid/ready channel carrying one rasterized pixel per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface blr_pixel_if;
    import blr_pkg::*;

    logic   valid;
    logic   ready;
    t_coord pixel_x;
    t_coord pixel_y;
    t_color pixel_color;
    logic   last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, pixel_color, last_pixel,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, pixel_color, last_pixel,
        output ready
    );
endinterface

`default_nettype wire

### rtl/bresenham_line_rasterizer.sv
// ----------------------------------------------------------------------------
// Bresenham line rasterizer
// All-octant line engine: load beats set up a line, step beats emit pixels.
// ----------------------------------------------------------------------------
// A load beat (action 0) takes two endpoints and a color and replaces any line
// in progress; it produces no pixel. Each step beat (action 1) emits the next
// pixel of the current line, flagged last_pixel on the final endpoint, after
// which the engine goes idle and further steps produce nothing. Lines are
// walked along the major axis (x on ties) from the lower major coordinate.
// The block takes one beat per clock; backpressure on the pixel channel stalls
// the command channel once the command register is full. A step beat's pixel
// passes through the command register, then the pixel register. The rate is set
// by the single step datapath (a subtract, an add, a sign test and a select)
// between them, which advances the line state once per cycle on step beats.
`default_nettype none

module bresenham_line_rasterizer (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    blr_line_if.sink   i_line,
    blr_pixel_if.source o_pixel
);
    import blr_pkg::*;

    logic   r_in_valid;
    t_item  r_in;
    logic   r_out_valid;
    t_pixel r_out;

    logic   proc_fire;
    logic   emit;
    t_pixel pix;

    assign proc_fire    = r_in_valid && (!r_out_valid || o_pixel.ready);
    assign i_line.ready = !r_in_valid || proc_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_line.ready) begin
            r_in_valid <= i_line.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_line.ready && i_line.valid) begin
            r_in.action  <= i_line.action;
            r_in.x_start <= i_line.x_start;
            r_in.y_start <= i_line.y_start;
            r_in.x_end   <= i_line.x_end;
            r_in.y_end   <= i_line.y_end;
            r_in.color   <= i_line.color;
        end
    end

    blr_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (proc_fire),
        .i_item  (r_in),
        .o_emit  (emit),
        .o_pixel (pix)
    );

    // pixel register: loads on emit, drains on a taken beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_pixel.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= pix;
        end
    end

    assign o_pixel.valid       = r_out_valid;
    assign o_pixel.pixel_x     = r_out.pixel_x;
    assign o_pixel.pixel_y     = r_out.pixel_y;
    assign o_pixel.pixel_color = r_out.pixel_color;
    assign o_pixel.last_pixel  = r_out.last_pixel;

endmodule

`default_nettype wire

### rtl/blr_core.sv
// ----------------------------------------------------------------------------
// Line rasterizer core
// Holds the line state; sets up a line on load and advances one pixel per step.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bresenham_line_rasterizer_assert.svh"

module blr_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_fire,
    input  wire blr_pkg::t_item i_item,
    output logic                o_emit,
    output blr_pkg::t_pixel     o_pixel
);
    import blr_pkg::*;

    // line state
    logic   r_busy;
    logic   r_steep;
    t_coord r_major_pos;
    t_coord r_minor_pos;
    t_coord r_major_stop;
    logic   r_minor_down;
    t_coord r_major_delta;
    t_coord r_minor_delta;
    t_err   r_err;
    t_color r_color;

    // load setup
    t_coord dx, dy;
    logic   steep;
    t_coord a0, a1, b0, b1;
    logic   swap;
    t_coord minor_first, minor_last;

    // step
    logic   last;
    t_err   err_sub, err_next;
    logic   minor_move;

    always_comb begin
        dx    = (i_item.x_start > i_item.x_end) ? (i_item.x_start - i_item.x_end)
                                                : (i_item.x_end - i_item.x_start);
        dy    = (i_item.y_start > i_item.y_end) ? (i_item.y_start - i_item.y_end)
                                                : (i_item.y_end - i_item.y_start);
        steep = dy > dx;
        a0    = steep ? i_item.y_start : i_item.x_start;
        a1    = steep ? i_item.y_end   : i_item.x_end;
        b0    = steep ? i_item.x_start : i_item.y_start;
        b1    = steep ? i_item.x_end   : i_item.y_end;
        swap  = a0 > a1;
        minor_first = swap ? b1 : b0;
        minor_last  = swap ? b0 : b1;
    end

    always_comb begin
        last       = r_major_pos == r_major_stop;
        err_sub    = r_err - $signed({1'b0, r_minor_delta});
        minor_move = err_sub[COORD_BITS];
        err_next   = minor_move ? (err_sub + $signed({1'b0, r_major_delta})) : err_sub;
    end

    assign o_emit              = i_fire && (i_item.action == ACT_STEP) && r_busy;
    assign o_pixel.pixel_x     = r_steep ? r_minor_pos : r_major_pos;
    assign o_pixel.pixel_y     = r_steep ? r_major_pos : r_minor_pos;
    assign o_pixel.pixel_color = r_color;
    assign o_pixel.last_pixel  = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_fire) begin
            if (i_item.action == ACT_LOAD) begin
                r_busy <= 1'b1;
            end else if (r_busy && last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            if (i_item.action == ACT_LOAD) begin
                r_steep       <= steep;
                r_major_pos   <= swap ? a1 : a0;
                r_major_stop  <= swap ? a0 : a1;
                r_minor_pos   <= minor_first;
                r_minor_down  <= minor_last < minor_first;
                r_major_delta <= steep ? dy : dx;
                r_minor_delta <= steep ? dx : dy;
                r_err         <= $signed({1'b0, (steep ? dy : dx) >> 1});
                r_color       <= i_item.color;
            end else if (r_busy && !last) begin
                r_major_pos <= r_major_pos + 1'b1;
                r_err       <= err_next;
                if (minor_move) begin
                    r_minor_pos <= r_minor_down ? (r_minor_pos - 1'b1)
                                                : (r_minor_pos + 1'b1);
                end
            end
        end
    end

    `BLR_ASSERT(a_load_sets_busy, i_clk, i_rst_n,
        (i_fire && i_item.action == ACT_LOAD) |=> r_busy)
    `BLR_ASSERT(a_last_clears_busy, i_clk, i_rst_n,
        (o_emit && o_pixel.last_pixel) |=> !r_busy)
    `BLR_ASSERT(a_pos_in_span, i_clk, i_rst_n,
        r_busy |-> (r_major_pos <= r_major_stop))
    `BLR_ASSERT(a_err_nonneg, i_clk, i_rst_n,
        r_busy |-> (!r_err[COORD_BITS] && (r_major_delta >= r_minor_delta)))

endmodule

`default_nettype wire

### test/tb_bresenham_line_rasterizer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line rasterizer testbench
// Drives load and step beats with random stalls on both channels, runs a
// line model alongside the block and checks every pixel field by field.
// ----------------------------------------------------------------------------

module tb_bresenham_line_rasterizer;
    import blr_pkg::*;

    localparam int   COORD_MAX  = (1 << COORD_BITS) - 1;
    localparam int   STALL_LIMIT = 2000;
    localparam int   TAIL_CYCLES = 10;

    logic i_clk = 1'b0;
    logic i_rst_n;

    blr_line_if  line_bus ();
    blr_pixel_if pixel_bus ();

    bresenham_line_rasterizer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_line  (line_bus),
        .o_pixel (pixel_bus)
    );

    always #10 i_clk = ~i_clk;

    // line model state
    logic   ln_busy;
    logic   ln_steep;
    t_coord ln_major;
    t_coord ln_minor;
    t_coord ln_stop;
    logic   ln_down;
    t_coord ln_major_delta;
    t_coord ln_minor_delta;
    t_err   ln_err;
    t_color ln_color;

    t_pixel pixels_due[$];

    int src_idle;
    int snk_idle;
    int mismatches;
    int items_sent;
    int lines_loaded;
    int steps_sent;
    int pixels_checked;
    int idle_cycles;

    // ------------------------------------------------------------------------
    // line model: update on every accepted command beat
    // ------------------------------------------------------------------------
    task automatic rasterize_beat(input t_item it);
        t_coord dx;
        t_coord dy;
        t_coord a0;
        t_coord a1;
        t_coord b0;
        t_coord b1;
        t_coord tmp;
        t_err   e;
        t_pixel px;
        if (it.action == ACT_LOAD) begin
            dx = (it.x_end > it.x_start) ? it.x_end - it.x_start : it.x_start - it.x_end;
            dy = (it.y_end > it.y_start) ? it.y_end - it.y_start : it.y_start - it.y_end;
            ln_steep = dy > dx;
            if (ln_steep) begin
                a0 = it.y_start; b0 = it.x_start; a1 = it.y_end; b1 = it.x_end;
            end else begin
                a0 = it.x_start; b0 = it.y_start; a1 = it.x_end; b1 = it.y_end;
            end
            if (a0 > a1) begin
                tmp = a0; a0 = a1; a1 = tmp;
                tmp = b0; b0 = b1; b1 = tmp;
            end
            ln_major       = a0;
            ln_stop        = a1;
            ln_minor       = b0;
            ln_down        = b1 < b0;
            ln_major_delta = a1 - a0;
            ln_minor_delta = (b1 > b0) ? b1 - b0 : b0 - b1;
            ln_err         = t_err'({2'b00, ln_major_delta[COORD_BITS-1:1]});
            ln_color       = it.color;
            ln_busy        = 1'b1;
            lines_loaded++;
        end else if (ln_busy) begin
            px.pixel_x     = ln_steep ? ln_minor : ln_major;
            px.pixel_y     = ln_steep ? ln_major : ln_minor;
            px.pixel_color = ln_color;
            px.last_pixel  = (ln_major == ln_stop);
            pixels_due.push_back(px);
            if (px.last_pixel) begin
                ln_busy = 1'b0;
            end else begin
                ln_major = ln_major + 1'b1;
                e = ln_err - t_err'({1'b0, ln_minor_delta});
                if (e < 0) begin
                    e = e + t_err'({1'b0, ln_major_delta});
                    ln_minor = ln_down ? ln_minor - 1'b1 : ln_minor + 1'b1;
                end
                ln_err = e;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h (t=%0t)", what, got, want, $realtime);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // pixel checker, receiver stalls and watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && pixel_bus.valid && pixel_bus.ready) begin
            if (pixels_due.size() == 0) begin
                report_mismatch("unexpected pixel, x", pixel_bus.pixel_x, '0);
            end else begin
                want = pixels_due.pop_front();
                pixels_checked++;
                if (pixel_bus.pixel_x !== want.pixel_x)
                    report_mismatch("pixel_x", pixel_bus.pixel_x, want.pixel_x);
                if (pixel_bus.pixel_y !== want.pixel_y)
                    report_mismatch("pixel_y", pixel_bus.pixel_y, want.pixel_y);
                if (pixel_bus.pixel_color !== want.pixel_color)
                    report_mismatch("pixel_color", pixel_bus.pixel_color, want.pixel_color);
                if (pixel_bus.last_pixel !== want.last_pixel)
                    report_mismatch("last_pixel", pixel_bus.last_pixel, want.last_pixel);
            end
        end
    end

    always @(posedge i_clk) begin
        pixel_bus.ready <= ($urandom_range(0, 99) >= snk_idle);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (line_bus.valid && line_bus.ready)
                || (pixel_bus.valid && pixel_bus.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat for %0d cycles", STALL_LIMIT);
            $display("** bresenham_line_rasterizer: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_item load_item(input int xs, input int ys, input int xe,
                                        input int ye, input logic [31:0] col);
        t_item it;
        it.action  = ACT_LOAD;
        it.x_start = t_coord'(xs);
        it.y_start = t_coord'(ys);
        it.x_end   = t_coord'(xe);
        it.y_end   = t_coord'(ye);
        it.color   = col;
        return it;
    endfunction

    // step beat with junk in the coordinate fields, which the block ignores
    function automatic t_item step_item();
        t_item it;
        it        = load_item($urandom, $urandom, $urandom, $urandom, $urandom);
        it.action = ACT_STEP;
        return it;
    endfunction

    function automatic int clamp_coord(input int v);
        return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

    function automatic t_item random_line(input bit wide);
        int xs;
        int ys;
        int dx;
        int dy;
        xs = $urandom_range(0, COORD_MAX);
        ys = $urandom_range(0, COORD_MAX);
        dx = wide ? $urandom_range(0, COORD_MAX) : $urandom_range(0, 12);
        dy = wide ? $urandom_range(0, COORD_MAX) : $urandom_range(0, 12);
        if ($urandom_range(0, 1)) dx = -dx;
        if ($urandom_range(0, 1)) dy = -dy;
        return load_item(xs, ys, clamp_coord(xs + dx), clamp_coord(ys + dy), $urandom);
    endfunction

    task automatic send_item(input t_item it);
        while ($urandom_range(0, 99) < src_idle) begin
            line_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        line_bus.valid   <= 1'b1;
        line_bus.action  <= it.action;
        line_bus.x_start <= it.x_start;
        line_bus.y_start <= it.y_start;
        line_bus.x_end   <= it.x_end;
        line_bus.y_end   <= it.y_end;
        line_bus.color   <= it.color;
        do @(posedge i_clk); while (!line_bus.ready);
        items_sent++;
        if (it.action == ACT_STEP) steps_sent++;
        rasterize_beat(it);
    endtask

    task automatic step_n(input int n);
        repeat (n) send_item(step_item());
    endtask

    // hold the command channel off until every pixel owed has come out
    task automatic wait_drained();
        line_bus.valid <= 1'b0;
        while (pixels_due.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        src_idle = 16;
        snk_idle = 68;
        send_item(step_item());                             // step while idle
        send_item(load_item(0, 0, 0, 0, 32'hFFFF_FFFF));  // single point
        step_n(2);                                          // second step is dropped
        send_item(load_item(COORD_MAX, COORD_MAX, COORD_MAX - 3, COORD_MAX - 3,
                            32'h8000_0000));               // tie, reversed
        step_n(4);
        send_item(load_item(COORD_MAX, 0, COORD_MAX - 2, COORD_MAX, 32'h5A5A_A5A5));
        step_n(2);                                          // left unfinished
        send_item(load_item(0, COORD_MAX, 2, COORD_MAX - 5, 32'h0000_0000));
        step_n(6);                                          // steep, minor falls
        send_item(load_item(4, 5, 0, 7, 32'h0F0F_F0F0));  // shallow, minor falls
        step_n(5);
        wait_drained();
    endtask

    task automatic test_random(input int n_items, input int src_pct, input int snk_pct);
        int first;
        int kind;
        int steps;
        src_idle = src_pct;
        snk_idle = snk_pct;
        first    = items_sent;
        while (items_sent - first < n_items) begin
            kind = $urandom_range(0, 99);
            if (kind < 75) begin
                send_item(random_line(1'b0));
                steps = int'(ln_stop - ln_major) + 1 + $urandom_range(0, 2);
                if ($urandom_range(0, 9) == 0) steps = $urandom_range(0, steps);
                step_n(steps);
            end else if (kind < 90) begin
                // noise: any beat with any field values
                if ($urandom_range(0, 1)) send_item(step_item());
                else send_item(random_line(1'b1));
            end else begin
                send_item(random_line(1'b1));
                step_n($urandom_range(1, 40));
            end
        end
        wait_drained();
    endtask

    // long shallow line from the maximum-y edge to the right edge, run with no stalls
    task automatic test_full_span();
        src_idle = 0;
        snk_idle = 0;
        send_item(load_item(COORD_MAX - 95, COORD_MAX, COORD_MAX, COORD_MAX - 31, $urandom));
        step_n(98);
        wait_drained();
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        line_bus.valid    <= 1'b0;
        line_bus.action   <= ACT_LOAD;
        line_bus.x_start  <= '0;
        line_bus.y_start  <= '0;
        line_bus.x_end    <= '0;
        line_bus.y_end    <= '0;
        line_bus.color    <= '0;
        src_idle       = 0;
        snk_idle       = 0;
        mismatches     = 0;
        items_sent     = 0;
        lines_loaded   = 0;
        steps_sent     = 0;
        pixels_checked = 0;
        ln_busy        = 1'b0;
        ln_steep       = 1'b0;
        ln_major       = '0;
        ln_minor       = '0;
        ln_stop        = '0;
        ln_down        = 1'b0;
        ln_major_delta = '0;
        ln_minor_delta = '0;
        ln_err         = '0;
        ln_color       = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(120, 16, 68);
        test_random(120, 68, 16);
        test_random(120, 0, 0);
        test_full_span();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Covered %0d beats: %0d line loads, %0d steps, %0d pixels checked.",
                 items_sent, lines_loaded, steps_sent, pixels_checked);
        $display("All octants, ties, single points, replaced lines and one long edge line.");
        if (mismatches == 0) begin
            $display("** bresenham_line_rasterizer: PASSED **");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("** bresenham_line_rasterizer: FAILED **");
        end
        $finish;
    end

endmodule
